@@ sv/lhm_pkg.sv @@
// Package for the LZ77 hash-chain lazy matcher.
// Holds payload structs, command and phase codes and sizing constants.
// Used by every module of the block; depends on nothing.
package lhm_pkg;

  localparam int BLOCK_DEPTH   = 4096;
  localparam int ADDR_W        = $clog2(BLOCK_DEPTH);
  localparam int POS_W         = ADDR_W + 1;
  localparam int HASH_W        = 15;
  localparam int HASH_DEPTH    = 1 << HASH_W;
  localparam int MAX_LEN       = 255;
  localparam int MATCH_LEN_MIN = 3;
  localparam int CFG_DATA_W    = 15;

  localparam logic [5:0]  CHAIN_LIMIT_RST  = 6'd32;
  localparam logic [7:0]  GOOD_LENGTH_RST  = 8'd32;
  localparam logic [14:0] MAX_DISTANCE_RST = 15'd32767;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [14:0] distance;
    logic [7:0]  value;
    logic        final_token;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  chain_limit;
    logic [7:0]  good_length;
    logic [14:0] max_distance;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_CHAIN_LIMIT  = 2'd0,
    CFG_GOOD_LENGTH  = 2'd1,
    CFG_MAX_DISTANCE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_REQ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic       last_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_MATCHING = 2'd1,
    PH_PENDING  = 2'd2,
    PH_DONE     = 2'd3
  } phase_e;

endpackage

@@ sv/lhm_front.sv @@
// Front end: accepts input beats, decodes them into commands and queues them.
// Depends on lhm_pkg.
module lhm_front import lhm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t item_i,
  input  logic     clearing_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept;
  cmd_t       cmd_in;

  // No beats are taken while the hash heads are being cleared.
  assign full_o      = (cnt_q == 2'd2) || clearing_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  // Decode the function bit into a command.
  always_comb begin
    cmd_in.op        = item_i.func ? OP_REQ : OP_LOAD;
    cmd_in.data_byte = item_i.data_byte;
    cmd_in.last_byte = item_i.last_byte;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, accept} - {1'b0, cmd_pop_i};
    end
  end

endmodule

@@ sv/lhm_outq.sv @@
// Result queue of two entries between the matcher engine and the output port.
// Depends on lhm_pkg.
module lhm_outq import lhm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      space_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  out_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       deq;

  assign empty_o = (cnt_q == 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign item_o  = mem_q[rd_ptr_q];
  assign deq     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (deq) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, deq};
    end
  end

endmodule

@@ sv/lhm_back.sv @@
// Back end: loads the block, builds hash chains, searches matches lazily and
// emits at most one token per request. Holds the byte, link and head memories.
// Depends on lhm_pkg.
module lhm_back import lhm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      out_space_i,
  output logic      res_push_o,
  output out_item_t res_o,
  output logic      clearing_o
);

  typedef enum logic [11:0] {
    ST_CLR   = 12'b0000_0000_0001,
    ST_IDLE  = 12'b0000_0000_0010,
    ST_HREAD = 12'b0000_0000_0100,
    ST_HWR   = 12'b0000_0000_1000,
    ST_LINIT = 12'b0000_0001_0000,
    ST_LLINK = 12'b0000_0010_0000,
    ST_CRD   = 12'b0000_0100_0000,
    ST_CCMP  = 12'b0000_1000_0000,
    ST_LFIN  = 12'b0001_0000_0000,
    ST_LAZY  = 12'b0010_0000_0000,
    ST_LIT   = 12'b0100_0000_0000,
    ST_EMIT  = 12'b1000_0000_0000
  } state_e;

  // Memories.
  logic [7:0]       byte_mem [BLOCK_DEPTH];
  logic [POS_W-1:0] prev_mem [BLOCK_DEPTH];
  logic [POS_W-1:0] head_mem [HASH_DEPTH];

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [POS_W-1:0]  blen_q, blen_d, cursor_q, cursor_d;
  logic [POS_W-1:0]  pstart_q, pstart_d;
  logic [14:0]       pdist_q, pdist_d;
  logic [7:0]        plen_q, plen_d;
  logic [7:0]        bm1_q, bm1_d, bm2_q, bm2_d;
  logic [HASH_W-1:0] h_q, h_d, clr_q, clr_d;
  logic [POS_W-1:0]  qpos_q, qpos_d;
  // Longest-match search registers.
  logic [POS_W-1:0]  ln_start_q, ln_start_d, cand_q, cand_d, s_q, s_d, r_q, r_d;
  logic [7:0]        best_q, best_d, n_q, n_d;
  logic [14:0]       ldist_q, ldist_d;
  logic [6:0]        count_q, count_d;
  // Lazy-match registers.
  logic              first_q, first_d;
  logic [7:0]        lz_len_q, lz_len_d;
  logic [14:0]       lz_dist_q, lz_dist_d;
  logic [POS_W-1:0]  lz_cur_q, lz_cur_d;
  // Token being emitted.
  logic [14:0]       em_dist_q, em_dist_d;
  logic [7:0]        em_len_q, em_len_d;
  logic              em_lit_q, em_lit_d;
  logic [POS_W-1:0]  em_cur_q, em_cur_d;
  phase_e            em_phase_q, em_phase_d;

  // Memory ports.
  logic              byte_we, prev_we, head_we;
  logic [ADDR_W-1:0] byte_waddr, prev_waddr, prev_raddr, a_addr, b_addr;
  logic [7:0]        byte_wdata, rd_a_q, rd_b_q;
  logic [POS_W-1:0]  prev_wdata, head_wdata, prev_rd_q, head_rd_q;
  logic [HASH_W-1:0] head_addr;

  logic [POS_W-1:0]  eff_blen, link_cand, gap;
  logic              final_tok;

  assign clearing_o = (state_q == ST_CLR);
  assign a_addr     = (state_q == ST_CRD) ? s_q[ADDR_W-1:0] : cursor_q[ADDR_W-1:0];
  assign b_addr     = r_q[ADDR_W-1:0];
  assign prev_raddr = (state_q == ST_LFIN) ? cand_q[ADDR_W-1:0] : ln_start_q[ADDR_W-1:0];
  assign head_addr  = (state_q == ST_CLR) ? clr_q : h_q;
  assign link_cand  = prev_rd_q - POS_W'(1);
  assign gap        = ln_start_q - link_cand;
  assign final_tok  = (em_cur_q >= blen_q);
  // A finished block counts as empty for the next load.
  assign eff_blen   = (phase_q == PH_DONE) ? '0 : blen_q;

  // Byte store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
    rd_a_q <= byte_mem[a_addr];
    rd_b_q <= byte_mem[b_addr];
  end

  // Chain links: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_rd_q <= prev_mem[prev_raddr];
  end

  // Hash heads: single address port, read before write.
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_addr] <= head_wdata;
    head_rd_q <= head_mem[head_addr];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;   phase_d = phase_q;   blen_d = blen_q;   cursor_d = cursor_q;
    pstart_d = pstart_q; pdist_d = pdist_q;   plen_d = plen_q;
    bm1_d = bm1_q;       bm2_d = bm2_q;       h_d = h_q;         clr_d = clr_q;
    qpos_d = qpos_q;     ln_start_d = ln_start_q; cand_d = cand_q;
    s_d = s_q;           r_d = r_q;           best_d = best_q;   n_d = n_q;
    ldist_d = ldist_q;   count_d = count_q;   first_d = first_q;
    lz_len_d = lz_len_q; lz_dist_d = lz_dist_q; lz_cur_d = lz_cur_q;
    em_dist_d = em_dist_q; em_len_d = em_len_q; em_lit_d = em_lit_q;
    em_cur_d = em_cur_q; em_phase_d = em_phase_q;
    cmd_pop_o = 1'b0;    res_push_o = 1'b0;
    res_o = '{distance: em_dist_q, value: em_lit_q ? rd_a_q : em_len_q,
              final_token: final_tok};
    byte_we = 1'b0; byte_waddr = eff_blen[ADDR_W-1:0]; byte_wdata = cmd_i.data_byte;
    prev_we = 1'b0; prev_waddr = qpos_q[ADDR_W-1:0]; prev_wdata = head_rd_q;
    head_we = 1'b0; head_wdata = qpos_q + POS_W'(1);

    case (state_q)
      // Sweep all hash heads to empty.
      ST_CLR: begin
        head_we    = 1'b1;
        head_wdata = '0;
        clr_d      = clr_q + HASH_W'(1);
        if (clr_q == HASH_W'(HASH_DEPTH - 1)) state_d = ST_IDLE;
      end
      // Take the next command once the result queue has room.
      ST_IDLE: begin
        if (cmd_valid_i && out_space_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_LOAD) begin
            if (phase_q == PH_DONE || phase_q == PH_LOADING) begin
              if (phase_q == PH_DONE) begin
                cursor_d = '0; pstart_d = '0; pdist_d = '0; plen_d = '0;
                phase_d  = PH_LOADING;
              end
              blen_d = eff_blen;
              if (eff_blen < POS_W'(BLOCK_DEPTH)) begin
                byte_we = 1'b1;
                blen_d  = eff_blen + POS_W'(1);
                bm2_d   = bm1_q;
                bm1_d   = cmd_i.data_byte;
                if (eff_blen >= POS_W'(2)) begin
                  h_d     = {bm2_q[4:0], bm1_q[4:0], cmd_i.data_byte[4:0]};
                  qpos_d  = eff_blen - POS_W'(2);
                  state_d = ST_HREAD;
                end
              end
              // The block is never empty here, so the last byte starts matching.
              if (cmd_i.last_byte) phase_d = PH_MATCHING;
            end
          end else if (phase_q == PH_MATCHING || phase_q == PH_PENDING) begin
            if (cursor_q >= blen_q) begin
              phase_d = PH_DONE;
              clr_d   = '0;
              state_d = ST_CLR;
            end else if (phase_q == PH_PENDING) begin
              if (cursor_q < pstart_q) begin
                em_dist_d = '0; em_lit_d = 1'b1; em_cur_d = cursor_q + POS_W'(1);
                em_phase_d = PH_PENDING;
              end else begin
                em_dist_d = pdist_q; em_len_d = plen_q; em_lit_d = 1'b0;
                em_cur_d = pstart_q + POS_W'(plen_q); em_phase_d = PH_MATCHING;
              end
              state_d = ST_LIT;
            end else begin
              first_d = 1'b1; ln_start_d = cursor_q; best_d = '0; count_d = '0;
              state_d = ST_LINIT;
            end
          end
        end
      end
      ST_HREAD: state_d = ST_HWR;
      // Link the new position in front of its chain.
      ST_HWR: begin
        prev_we = 1'b1;
        head_we = 1'b1;
        state_d = ST_IDLE;
      end
      // A search needs three bytes from the start.
      ST_LINIT: begin
        if (blen_q < POS_W'(MATCH_LEN_MIN) || (ln_start_q + POS_W'(2)) >= blen_q) begin
          state_d = ST_LAZY;
        end else begin
          state_d = ST_LLINK;
        end
      end
      // Follow the chain to the next candidate or stop.
      ST_LLINK: begin
        if (prev_rd_q == '0 || link_cand >= ln_start_q ||
            15'(gap) >= cfg_i.max_distance ||
            count_q > {1'b0, cfg_i.chain_limit} || best_q >= cfg_i.good_length) begin
          state_d = ST_LAZY;
        end else begin
          cand_d = link_cand; s_d = ln_start_q; r_d = link_cand; n_d = '0;
          state_d = ST_CRD;
        end
      end
      // Compare one byte pair per pass through ST_CRD and ST_CCMP.
      ST_CRD: begin
        if (s_q < blen_q && n_q < 8'(MAX_LEN)) state_d = ST_CCMP;
        else state_d = ST_LFIN;
      end
      ST_CCMP: begin
        if (rd_a_q == rd_b_q) begin
          n_d = n_q + 8'd1; s_d = s_q + POS_W'(1); r_d = r_q + POS_W'(1);
          state_d = ST_CRD;
        end else begin
          state_d = ST_LFIN;
        end
      end
      // Keep a strictly longer match and fetch the next link.
      ST_LFIN: begin
        if (n_q >= 8'(MATCH_LEN_MIN) && n_q > best_q) begin
          best_d  = n_q;
          ldist_d = 15'(ln_start_q - cand_q);
        end
        count_d = count_q + 7'd1;
        state_d = ST_LLINK;
      end
      // Lazy evaluation of each finished search.
      ST_LAZY: begin
        state_d = ST_LINIT;
        best_d  = '0;
        count_d = '0;
        if (first_q) begin
          if (best_q == '0) begin
            em_dist_d = '0; em_lit_d = 1'b1; em_cur_d = cursor_q + POS_W'(1);
            em_phase_d = PH_MATCHING;
            state_d = ST_LIT;
          end else begin
            first_d = 1'b0; lz_len_d = best_q; lz_dist_d = ldist_q;
            lz_cur_d = cursor_q; ln_start_d = cursor_q + POS_W'(1);
          end
        end else if (best_q <= lz_len_q || best_q >= cfg_i.good_length) begin
          state_d = ST_LIT;
          if (lz_cur_q == cursor_q) begin
            em_dist_d = lz_dist_q; em_len_d = lz_len_q; em_lit_d = 1'b0;
            em_cur_d = cursor_q + POS_W'(lz_len_q); em_phase_d = PH_MATCHING;
          end else begin
            pstart_d = lz_cur_q; pdist_d = lz_dist_q; plen_d = lz_len_q;
            em_dist_d = '0; em_lit_d = 1'b1; em_cur_d = cursor_q + POS_W'(1);
            em_phase_d = PH_PENDING;
          end
        end else begin
          lz_len_d = best_q; lz_dist_d = ldist_q; lz_cur_d = lz_cur_q + POS_W'(1);
          ln_start_d = lz_cur_q + POS_W'(2);
        end
      end
      // Fetch the byte at the cursor for a literal.
      ST_LIT: state_d = ST_EMIT;
      ST_EMIT: begin
        res_push_o = 1'b1;
        cursor_d   = em_cur_q;
        if (final_tok) begin
          phase_d = PH_DONE;
          clr_d   = '0;
          state_d = ST_CLR;
        end else begin
          phase_d = em_phase_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;   phase_q <= PH_LOADING; blen_q <= '0;  cursor_q <= '0;
      pstart_q <= '0;      pdist_q <= '0;  plen_q <= '0;  bm1_q <= '0;  bm2_q <= '0;
      h_q <= '0;           clr_q <= '0;    qpos_q <= '0;  ln_start_q <= '0;
      cand_q <= '0;        s_q <= '0;      r_q <= '0;     best_q <= '0; n_q <= '0;
      ldist_q <= '0;       count_q <= '0;  first_q <= 1'b0;
      lz_len_q <= '0;      lz_dist_q <= '0; lz_cur_q <= '0;
      em_dist_q <= '0;     em_len_q <= '0; em_lit_q <= 1'b0; em_cur_q <= '0;
      em_phase_q <= PH_MATCHING;
    end else begin
      state_q <= state_d;  phase_q <= phase_d; blen_q <= blen_d; cursor_q <= cursor_d;
      pstart_q <= pstart_d; pdist_q <= pdist_d; plen_q <= plen_d;
      bm1_q <= bm1_d;      bm2_q <= bm2_d;  h_q <= h_d;  clr_q <= clr_d;
      qpos_q <= qpos_d;    ln_start_q <= ln_start_d; cand_q <= cand_d;
      s_q <= s_d;          r_q <= r_d;      best_q <= best_d; n_q <= n_d;
      ldist_q <= ldist_d;  count_q <= count_d; first_q <= first_d;
      lz_len_q <= lz_len_d; lz_dist_q <= lz_dist_d; lz_cur_q <= lz_cur_d;
      em_dist_q <= em_dist_d; em_len_q <= em_len_d; em_lit_q <= em_lit_d;
      em_cur_q <= em_cur_d; em_phase_q <= em_phase_d;
    end
  end

endmodule

@@ sv/lz77_hash_chain_lazy_matcher_unit.sv @@
// Top level of the LZ77 hash-chain lazy matcher.
// Instantiates lhm_front, lhm_back and lhm_outq; depends on lhm_pkg.
//
// Usage: input beats enter through push/full. A beat with func 0 loads one
// byte of the block (last_byte ends the block); a beat with func 1 asks for
// the next token. Tokens leave through empty/pop: distance 0 is a literal
// with the byte in value, otherwise value is the match length.
// Configuration (chain_limit, good_length, max_distance) is written through
// cfg_valid_i/cfg_ready_o, which is always ready; write it only while idle.
// A load is taken in ST_IDLE, and once it completes three bytes for a hash
// it also passes ST_HREAD and ST_HWR. A request served from a pending match
// passes ST_LIT and then ST_EMIT, which queues its token. A search adds
// ST_LINIT, ST_LLINK and ST_LAZY per lazy step, ST_CRD and ST_CCMP per
// compared byte and ST_LFIN per chain candidate, before ST_LIT and ST_EMIT.
// Throughput is set by the shared byte-compare loop on the two read ports of
// the byte store; up to two commands queue in front, two tokens behind.
// Reset and the end of each block start a clearing pass over all 32768 hash
// heads; full stays high during it. A stalled receiver only stops
// the engine once two tokens are waiting.
module lz77_hash_chain_lazy_matcher_unit import lhm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  cmd_t      cmd;
  logic      cmd_valid, cmd_pop, clearing, out_space, res_push;
  out_item_t res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chain_limit  <= CHAIN_LIMIT_RST;
      cfg_q.good_length  <= GOOD_LENGTH_RST;
      cfg_q.max_distance <= MAX_DISTANCE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHAIN_LIMIT:  cfg_q.chain_limit  <= cfg_data_i[5:0];
        CFG_GOOD_LENGTH:  cfg_q.good_length  <= cfg_data_i[7:0];
        CFG_MAX_DISTANCE: cfg_q.max_distance <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  lhm_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item_i),
    .clearing_i(clearing), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  lhm_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_pop_o(cmd_pop), .out_space_i(out_space), .res_push_o(res_push),
    .res_o(res), .clearing_o(clearing)
  );

  lhm_outq u_outq (
    .clk_i, .rst_ni, .push_i(res_push), .item_i(res), .space_o(out_space),
    .pop_i(pop), .empty_o(empty), .item_o(out_item_o)
  );

endmodule

@@ sv/lhm_checker.sv @@
// Port-level checker for the LZ77 hash-chain lazy matcher, bound to the top.
// Depends on lhm_pkg.
module lhm_checker import lhm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // A waiting token is not dropped while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting token lost");

  // A stalled token keeps its fields.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_item_o))
    else $error("stalled token changed");

  // A match is never shorter than three bytes.
  a_minlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.distance == 15'd0 || out_item_o.value >= 8'(MATCH_LEN_MIN)))
    else $error("match shorter than the minimum");

endmodule

bind lz77_hash_chain_lazy_matcher_unit lhm_checker u_chk (.*);

@@ sim/tb_top.sv @@
// Testbench for the LZ77 hash-chain lazy matcher unit.
// Drives byte loads and token requests, predicts every token and checks it.
// Depends on lhm_pkg and lz77_hash_chain_lazy_matcher_unit.
`timescale 1ns / 100ps

module tb_top;
  import lhm_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_item_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lz77_hash_chain_lazy_matcher_unit dut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  // Shadow of the matcher state.
  bit [7:0]  mem_bytes [BLOCK_DEPTH];
  bit [12:0] chain_prev [BLOCK_DEPTH];
  bit [12:0] chain_head [HASH_DEPTH];
  int        blk_len, cur, pend_start, pend_dist, pend_len;
  phase_e    ph;
  int        cfg_chain, cfg_good, cfg_maxd;

  out_item_t token_q[$];
  int        err_cnt = 0;
  int        items_sent = 0;
  bit        gaps_on = 1'b1;
  bit        pop_gaps_on = 1'b1;
  bit        hold_req = 1'b0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic void clear_shadow();
    for (int i = 0; i < BLOCK_DEPTH; i++) begin
      mem_bytes[i] = '0;
      chain_prev[i] = '0;
    end
    for (int i = 0; i < HASH_DEPTH; i++) chain_head[i] = '0;
    blk_len = 0;
    cur = 0;
    pend_start = 0;
    pend_dist = 0;
    pend_len = 0;
    ph = PH_LOADING;
  endfunction

  // Longest match at start over the hash chain, nearest candidate first.
  function automatic int longest_at(int start, output int mdist);
    int best, count, link, cand, n, s, r;
    best = 0;
    count = 0;
    mdist = 0;
    if (blk_len < MATCH_LEN_MIN || start + 2 >= blk_len) return 0;
    link = chain_prev[start];
    while (link != 0) begin
      cand = link - 1;
      if (cand >= start) break;
      if (start - cand >= cfg_maxd) break;
      if (count > cfg_chain) break;
      if (best >= cfg_good) break;
      n = 0;
      s = start;
      r = cand;
      while (s < blk_len && mem_bytes[s] == mem_bytes[r] && n < MAX_LEN) begin
        s++;
        r++;
        n++;
      end
      if (n >= MATCH_LEN_MIN && n > best) begin
        best = n;
        mdist = start - cand;
      end
      count++;
      link = chain_prev[cand];
    end
    return best;
  endfunction

  // Lazy search: step the start forward while the match keeps growing and stays below the good length.
  function automatic int lazy_search(int pos, output int start, output int mdist);
    int d, len, p, nd, nl;
    len = longest_at(pos, d);
    start = pos;
    mdist = 0;
    if (len == 0) return 0;
    p = pos;
    forever begin
      nl = longest_at(p + 1, nd);
      if (nl <= len || nl >= cfg_good) break;
      len = nl;
      d = nd;
      p++;
    end
    start = p;
    mdist = d;
    return len;
  endfunction

  function automatic void queue_token(int tdist, int val);
    out_item_t t;
    t.distance = tdist[14:0];
    t.value = val[7:0];
    t.final_token = (cur >= blk_len);
    if (cur >= blk_len) ph = PH_DONE;
    token_q.insert(token_q.size(), t);
  endfunction

  // Updates the shadow state for one accepted beat and queues its token, if any.
  function automatic void predict_beat(in_item_t it);
    int p, q, h, st, d, len, b;
    if (it.func == OP_LOAD) begin
      if (ph == PH_DONE) clear_shadow();
      if (ph != PH_LOADING) return;
      if (blk_len < BLOCK_DEPTH) begin
        p = blk_len;
        mem_bytes[p] = it.data_byte;
        blk_len = p + 1;
        if (p >= 2) begin
          q = p - 2;
          h = {mem_bytes[q][4:0], mem_bytes[q+1][4:0], mem_bytes[q+2][4:0]};
          chain_prev[q] = chain_head[h];
          chain_head[h] = 13'(q + 1);
        end
      end
      if (it.last_byte) ph = (blk_len == 0) ? PH_DONE : PH_MATCHING;
      return;
    end
    if (ph == PH_LOADING || ph == PH_DONE) return;
    if (cur >= blk_len) begin
      ph = PH_DONE;
      return;
    end
    if (ph == PH_PENDING) begin
      if (cur < pend_start) begin
        b = mem_bytes[cur];
        cur++;
        queue_token(0, b);
      end else begin
        cur = pend_start + pend_len;
        ph = PH_MATCHING;
        queue_token(pend_dist, pend_len);
      end
      return;
    end
    len = lazy_search(cur, st, d);
    if (len == 0) begin
      b = mem_bytes[cur];
      cur++;
      queue_token(0, b);
    end else if (st == cur) begin
      cur = st + len;
      queue_token(d, len);
    end else begin
      b = mem_bytes[cur];
      pend_start = st;
      pend_dist = d;
      pend_len = len;
      ph = PH_PENDING;
      cur++;
      queue_token(0, b);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one beat; returns at a falling edge with push still high.
  task automatic send_item(op_e op, logic [7:0] b, logic l);
    int gap;
    in_item_t it;
    gap = pick_gap();
    it.func = op;
    it.data_byte = b;
    it.last_byte = l;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    predict_beat(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CHAIN_LIMIT: cfg_chain = val & 'h3f;
      CFG_GOOD_LENGTH: cfg_good = val & 'hff;
      default:         cfg_maxd = val & 'h7fff;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every token has arrived and the engine has gone quiet.
  task automatic settle();
    push <= 1'b0;
    wait (token_q.size() == 0);
    repeat (4) @(negedge clk_i);
    wait (!full);
    repeat (300) @(negedge clk_i);
  endtask

  // Byte source: mode 0 any byte, 1 small alphabet with hash collisions,
  // 2 long runs of one byte.
  function automatic logic [7:0] gen_byte(int mode, logic [7:0] prev);
    logic [7:0] set4 [4] = '{8'h41, 8'h42, 8'hc1, 8'h43};
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return set4[$urandom_range(0, 3)];
      default: return ($urandom_range(0, 9) < 8) ? prev : 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Loads one block and asks for tokens until its final token, with noise if noisy is set.
  task automatic run_block(int len, int mode, bit noisy);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_item(OP_REQ, 8'($urandom_range(0, 255)), 1'b0);
      b = gen_byte(mode, b);
      send_item(OP_LOAD, b, i == len - 1);
    end
    while (ph != PH_DONE) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_item(OP_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        send_item(OP_REQ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    if (noisy) send_item(OP_REQ, 8'h00, 1'b0);
  endtask

  // Short repeated patterns at the reset settings, with the byte extremes.
  task automatic test_basic();
    logic [7:0] pat [12] = '{8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43,
                             8'h41, 8'h42, 8'h43, 8'h44, 8'hff, 8'h00};
    send_item(OP_REQ, 8'hff, 1'b1);
    for (int i = 0; i < 12; i++) send_item(OP_LOAD, pat[i], i == 11);
    send_item(OP_LOAD, 8'h55, 1'b0);
    while (ph != PH_DONE) send_item(OP_REQ, 8'h00, 1'b0);
    send_item(OP_REQ, 8'h00, 1'b0);
    settle();
  endtask

  // A block of one byte, whose first byte already carries the last flag.
  task automatic test_empty_block();
    send_item(OP_LOAD, 8'h80, 1'b1);
    send_item(OP_LOAD, 8'h7f, 1'b1);
    send_item(OP_REQ, 8'h00, 1'b0);
    settle();
  endtask

  // With a zero distance limit every token is a literal.
  task automatic test_zero_distance();
    cfg_write(CFG_MAX_DISTANCE, 0);
    run_block(9, 2, 1'b0);
    settle();
    cfg_write(CFG_MAX_DISTANCE, 32767);
  endtask

  // More bytes than the store holds; the last flag sits on a dropped byte.
  task automatic test_overflow();
    cfg_write(CFG_GOOD_LENGTH, 255);
    for (int i = 0; i < BLOCK_DEPTH + 4; i++)
      send_item(OP_LOAD, (i % 997 == 5) ? 8'h3c : 8'h5a, i == BLOCK_DEPTH + 3);
    while (ph != PH_DONE) send_item(OP_REQ, 8'h00, 1'b0);
    settle();
    cfg_write(CFG_GOOD_LENGTH, 32);
  endtask

  // Receiver holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_req = 1'b1;
    gaps_on = 1'b0;
    run_block(30, 0, 1'b0);
    gaps_on = 1'b1;
    settle();
  endtask

  // Random blocks over random and extreme settings.
  task automatic test_random();
    int r;
    while (items_sent < 1350) begin
      r = $urandom_range(0, 5);
      cfg_write(CFG_CHAIN_LIMIT, (r == 0) ? 0 : (r == 1) ? 63 : $urandom_range(0, 63));
      r = $urandom_range(0, 5);
      cfg_write(CFG_GOOD_LENGTH, (r == 0) ? 3 : (r == 1) ? 255 : $urandom_range(3, 255));
      r = $urandom_range(0, 7);
      cfg_write(CFG_MAX_DISTANCE, (r == 0) ? 1 : (r == 1) ? 32767 : (r == 2) ? 0 :
                $urandom_range(1, 64));
      gaps_on = ($urandom_range(0, 3) != 0);
      pop_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) run_block($urandom_range(260, 300), 2, 1'b1);
      else run_block($urandom_range(20, 60), $urandom_range(0, 2), 1'($urandom_range(0, 1)));
      settle();
    end
  endtask

  // Result side: random pop gaps, and one long hold when asked.
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (800) @(negedge clk_i);
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop_gaps_on && $urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 80);
      end
    end
  end

  // Each accepted token beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (token_q.size() == 0) begin
        report_mismatch("unexpected token, distance", out_item_o.distance, -1);
      end else begin
        want = token_q.pop_front();
        if (out_item_o.distance !== want.distance)
          report_mismatch("distance", out_item_o.distance, want.distance);
        if (out_item_o.value !== want.value)
          report_mismatch("value", out_item_o.value, want.value);
        if (out_item_o.final_token !== want.final_token)
          report_mismatch("final_token", out_item_o.final_token, want.final_token);
      end
    end
  end

  initial begin
    cfg_chain = CHAIN_LIMIT_RST;
    cfg_good = GOOD_LENGTH_RST;
    cfg_maxd = MAX_DISTANCE_RST;
    clear_shadow();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic();
    test_empty_block();
    test_zero_distance();
    test_backpressure();
    test_random();
    test_overflow();
    push <= 1'b0;
    wait (token_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
